[src/ubxfc_pkg.sv]
// Package for the UBX frame check and acknowledge block.
// Holds the channel payload structs, status codes and acknowledge frame constants.
// No dependencies.
package ubxfc_pkg;

  localparam logic [1:0] STATUS_GOOD  = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  localparam logic [7:0] SYNC_1    = 8'hB5;
  localparam logic [7:0] SYNC_2    = 8'h62;
  localparam logic [7:0] ACK_CLASS = 8'h05;
  localparam logic [7:0] ACK_ID    = 8'h01;

  localparam int unsigned ACK_LEN = 8;
  localparam logic [3:0] ACK_LEN_CAP = 4'd8;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ack_byte;
    logic       byte_valid;
    logic [1:0] frame_status;
    logic       last_result;
  } out_item_t;

  // Frame outcome handed from the tracker to the emitter on the last byte.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [7:0] class_byte;
    logic [7:0] id_byte;
  } outcome_t;

endpackage

[src/ubx_frame_check_and_ack.sv]
// Top level of the UBX frame check and acknowledge block.
// Instantiates ubxfc_frame_track and ubxfc_ack_emit; uses ubxfc_pkg.
//
//   channel | direction | payload            | accepted when
//   --------+-----------+--------------------+--------------------------
//   in      | input     | in_item_t          | in_valid && in_ready
//   out     | output    | out_item_t         | out_valid && out_ready
//   cfg     | input     | reply_capacity [4] | cfg_valid && cfg_ready
//
// One input byte per cycle. Bytes that do not end a frame are always taken.
// The final byte of a frame is held off (in_ready low) only while the previous
// frame's results are still draining; its own results follow from the next cycle,
// one per unstalled cycle: 1 status result, or 1..8 ack bytes per reply_capacity.
// Reset (rst, synchronous) clears frame state, the result sequencer, and sets
// reply_capacity to 8. Output stalls hold the current result unchanged.
module ubx_frame_check_and_ack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ubxfc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ubxfc_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data
);

  logic [3:0]          capacity;
  logic                load_free;
  logic                in_fire;
  ubxfc_pkg::outcome_t outcome;

  // config register always writable; user must write only while idle, unchecked
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ubxfc_pkg::ACK_LEN_CAP;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // only a frame-ending byte needs room in the result sequencer
  assign in_ready = !in_data.end_of_message || load_free;
  assign in_fire  = in_valid && in_ready;

  ubxfc_frame_track u_track (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .in_item (in_data),
    .outcome (outcome)
  );

  ubxfc_ack_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .reply_capacity (capacity),
    .outcome        (outcome),
    .load_free      (load_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  a_last_has_room: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.end_of_message |=> out_valid)
    else $error("frame end accepted without a pending result");

endmodule

[src/ubxfc_frame_track.sv]
// Per-byte frame tracker: Fletcher-8 with two-byte delay, class/id capture,
// and trailing checksum compare. Depends on ubxfc_pkg.
module ubxfc_frame_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ubxfc_pkg::in_item_t in_item,
  output ubxfc_pkg::outcome_t outcome
);

  logic [2:0] byte_position, byte_position_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic [7:0] byte_before_previous, byte_before_previous_next;
  logic [7:0] class_byte, class_byte_next;
  logic [7:0] id_byte, id_byte_next;

  logic [7:0] sa_upd, sb_upd, cls_upd, id_upd;

  always_comb begin
    sa_upd  = sum_a;
    sb_upd  = sum_b;
    cls_upd = class_byte;
    id_upd  = id_byte;
    if (byte_position >= 3'd4) begin
      sa_upd = sum_a + byte_before_previous;
      sb_upd = sum_b + sa_upd;
    end
    if (byte_position == 3'd2) cls_upd = in_item.msg_byte;
    if (byte_position == 3'd3) id_upd  = in_item.msg_byte;

    outcome.valid      = fire && in_item.end_of_message;
    outcome.class_byte = cls_upd;
    outcome.id_byte    = id_upd;
    priority if (byte_position < 3'd3) begin
      outcome.status = ubxfc_pkg::STATUS_SHORT;
    end else if (previous_byte != sa_upd || in_item.msg_byte != sb_upd) begin
      outcome.status = ubxfc_pkg::STATUS_BAD;
    end else begin
      outcome.status = ubxfc_pkg::STATUS_GOOD;
    end

    byte_position_next        = byte_position;
    sum_a_next                = sum_a;
    sum_b_next                = sum_b;
    previous_byte_next        = previous_byte;
    byte_before_previous_next = byte_before_previous;
    class_byte_next           = class_byte;
    id_byte_next              = id_byte;
    if (fire) begin
      if (in_item.end_of_message) begin
        // frame done: start clean
        byte_position_next        = '0;
        sum_a_next                = '0;
        sum_b_next                = '0;
        previous_byte_next        = '0;
        byte_before_previous_next = '0;
        class_byte_next           = '0;
        id_byte_next              = '0;
      end else begin
        sum_a_next                = sa_upd;
        sum_b_next                = sb_upd;
        class_byte_next           = cls_upd;
        id_byte_next              = id_upd;
        byte_before_previous_next = previous_byte;
        previous_byte_next        = in_item.msg_byte;
        if (byte_position < 3'd4) byte_position_next = byte_position + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      sum_a                <= '0;
      sum_b                <= '0;
      previous_byte        <= '0;
      byte_before_previous <= '0;
      class_byte           <= '0;
      id_byte              <= '0;
    end else begin
      byte_position        <= byte_position_next;
      sum_a                <= sum_a_next;
      sum_b                <= sum_b_next;
      previous_byte        <= previous_byte_next;
      byte_before_previous <= byte_before_previous_next;
      class_byte           <= class_byte_next;
      id_byte              <= id_byte_next;
    end
  end

  a_pos_sat: assert property (@(posedge clk) disable iff (rst) byte_position <= 3'd4)
    else $error("byte_position beyond saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.end_of_message |=> byte_position == 3'd0 && sum_a == 8'd0)
    else $error("frame state not cleared after last byte");

endmodule

[src/ubxfc_ack_emit.sv]
// Result sequencer: holds one frame outcome and plays out its results, one per
// transaction, from registers. Depends on ubxfc_pkg.
module ubxfc_ack_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           reply_capacity,
  input  ubxfc_pkg::outcome_t  outcome,
  output logic                 load_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ubxfc_pkg::out_item_t out_data
);

  logic       busy;
  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       send_bytes;
  logic [1:0] status;
  logic [7:0] class_byte, id_byte, ck_a, ck_b;

  logic       take;
  logic       is_last;
  logic [3:0] cap_sat;
  logic [7:0] ck_a_new, ck_b_new;
  logic [7:0] cur_byte;

  assign is_last   = idx == last_idx;
  assign take      = busy && out_ready;
  assign load_free = !busy || (out_ready && is_last);
  assign out_valid = busy;

  assign cap_sat = (reply_capacity > ubxfc_pkg::ACK_LEN_CAP) ? ubxfc_pkg::ACK_LEN_CAP
                                                               : reply_capacity;

  // Fletcher-8 over 05 01 class id
  always_comb begin
    logic [7:0] a1, a2, a3, b1, b2, b3;
    a1 = ubxfc_pkg::ACK_CLASS;
    b1 = a1;
    a2 = a1 + ubxfc_pkg::ACK_ID;
    b2 = b1 + a2;
    a3 = a2 + outcome.class_byte;
    b3 = b2 + a3;
    ck_a_new = a3 + outcome.id_byte;
    ck_b_new = b3 + ck_a_new;
  end

  always_comb begin
    unique case (idx)
      3'd0:    cur_byte = ubxfc_pkg::SYNC_1;
      3'd1:    cur_byte = ubxfc_pkg::SYNC_2;
      3'd2:    cur_byte = ubxfc_pkg::ACK_CLASS;
      3'd3:    cur_byte = ubxfc_pkg::ACK_ID;
      3'd4:    cur_byte = class_byte;
      3'd5:    cur_byte = id_byte;
      3'd6:    cur_byte = ck_a;
      default: cur_byte = ck_b;
    endcase
    out_data.ack_byte     = send_bytes ? cur_byte : 8'd0;
    out_data.byte_valid   = send_bytes;
    out_data.frame_status = status;
    out_data.last_result  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (outcome.valid && load_free) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (is_last) busy <= 1'b0;
      idx <= idx + 3'd1;
    end
  end

  // payload of the held outcome
  always_ff @(posedge clk) begin
    if (outcome.valid && load_free) begin
      status     <= outcome.status;
      class_byte <= outcome.class_byte;
      id_byte    <= outcome.id_byte;
      ck_a       <= ck_a_new;
      ck_b       <= ck_b_new;
      if (outcome.status == ubxfc_pkg::STATUS_GOOD && cap_sat != 4'd0) begin
        send_bytes <= 1'b1;
        last_idx   <= 3'(cap_sat - 4'd1);
      end else begin
        send_bytes <= 1'b0;
        last_idx   <= '0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst) busy |-> idx <= last_idx)
    else $error("result index past end of frame reply");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    busy && !send_bytes |-> last_idx == 3'd0)
    else $error("status-only reply longer than one result");

  a_bad_no_bytes: assert property (@(posedge clk) disable iff (rst)
    busy && status != ubxfc_pkg::STATUS_GOOD |-> !send_bytes)
    else $error("acknowledge bytes on a failed frame");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    busy && !out_ready |=> busy && $stable(idx))
    else $error("stalled result changed");

endmodule

[bench/ubxfc_checker.sv]
// Scoreboard for ubx_frame_check_and_ack: watches the in, out and cfg channels.
// It tracks the frame state, predicts each result and compares it with the DUT.
// Depends on ubxfc_pkg.
`timescale 1ns / 100ps
module ubxfc_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  ubxfc_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  ubxfc_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [3:0]           cfg_data,
  output int                   mismatches,
  output int                   replies_due
);

  logic [3:0]           capacity;
  logic [2:0]           bytes_seen;
  logic [7:0]           fl_a, fl_b, last_byte, older_byte, cls_byte, msg_id;
  ubxfc_pkg::out_item_t reply_q[$];

  task automatic restart_frame();
    bytes_seen = '0;
    fl_a       = '0;
    fl_b       = '0;
    last_byte  = '0;
    older_byte = '0;
    cls_byte   = '0;
    msg_id     = '0;
  endtask

  // Advance the frame tracker by one byte; on the final byte queue its results.
  task automatic frame_byte(input ubxfc_pkg::in_item_t item);
    logic [7:0] ack [8];
    logic [7:0] ck_a, ck_b;
    logic [2:0] pos;
    logic [1:0] status;
    int         n_ack;
    pos = bytes_seen;
    // the byte two back is now known not to be part of the check pair
    if (pos >= 3'd4) begin
      fl_a = fl_a + older_byte;
      fl_b = fl_b + fl_a;
    end
    if (pos == 3'd2) cls_byte = item.msg_byte;
    if (pos == 3'd3) msg_id = item.msg_byte;
    if (!item.end_of_message) begin
      older_byte = last_byte;
      last_byte  = item.msg_byte;
      if (bytes_seen < 3'd4) bytes_seen = bytes_seen + 3'd1;
    end else begin
      if (pos < 3'd3) status = ubxfc_pkg::STATUS_SHORT;
      else if (last_byte != fl_a || item.msg_byte != fl_b) status = ubxfc_pkg::STATUS_BAD;
      else status = ubxfc_pkg::STATUS_GOOD;
      ack[0] = ubxfc_pkg::SYNC_1;
      ack[1] = ubxfc_pkg::SYNC_2;
      ack[2] = ubxfc_pkg::ACK_CLASS;
      ack[3] = ubxfc_pkg::ACK_ID;
      ack[4] = cls_byte;
      ack[5] = msg_id;
      ck_a = '0;
      ck_b = '0;
      for (int i = 2; i < 6; i++) begin
        ck_a = ck_a + ack[i];
        ck_b = ck_b + ck_a;
      end
      ack[6] = ck_a;
      ack[7] = ck_b;
      n_ack = 0;
      if (status == ubxfc_pkg::STATUS_GOOD)
        n_ack = (capacity > ubxfc_pkg::ACK_LEN_CAP) ? int'(ubxfc_pkg::ACK_LEN)
                                                     : int'(capacity);
      if (n_ack == 0)
        reply_q.push_back('{ack_byte: 8'h00, byte_valid: 1'b0,
                            frame_status: status, last_result: 1'b1});
      for (int i = 0; i < n_ack; i++)
        reply_q.push_back('{ack_byte: ack[i], byte_valid: 1'b1,
                            frame_status: ubxfc_pkg::STATUS_GOOD,
                            last_result: (i == n_ack - 1)});
      restart_frame();
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ubxfc_pkg::out_item_t want;
    if (rst) begin
      capacity = 4'd8;
      restart_frame();
      reply_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && in_ready) frame_byte(in_data);
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: no result expected, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          compare_field("ack_byte", want.ack_byte, out_data.ack_byte);
          compare_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
          compare_field("frame_status", 8'(want.frame_status), 8'(out_data.frame_status));
          compare_field("last_result", 8'(want.last_result), 8'(out_data.last_result));
        end
      end
    end
    replies_due = reply_q.size();
  end

endmodule

[bench/tb.sv]
// Testbench top for ubx_frame_check_and_ack: clock, reset, stimulus and verdict.
// Feeds directed and random frames, sets reply_capacity between phases.
// Depends on ubxfc_pkg, ubx_frame_check_and_ack and ubxfc_checker.
`timescale 1ns / 100ps
module tb;

  // cycles without any transaction before the run is declared hung
  localparam int QUIET_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  ubxfc_pkg::in_item_t  in_data = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ubxfc_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic [3:0]           cfg_data = '0;
  logic                 cfg_ready;

  int mismatches;
  int replies_due;
  int in_gap_pct = 13;     // chance per cycle that the sender holds back
  int out_stall_pct = 55;  // chance per cycle that the receiver stalls
  int quiet_cycles = 0;

  // bytes of the frame being built, offset 0 first
  logic [7:0] frame_q[$];

  always #10 clk = ~clk;

  ubx_frame_check_and_ack u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ubxfc_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  // Receiver: ready is redrawn every cycle, independent of out_valid.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One input transaction. Called and returns at a rising edge; valid is left
  // high so a following byte can go out back to back.
  task automatic push_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{msg_byte: b, end_of_message: eom};
    // ready is stable at the falling edge; high there means taken at the next rise
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Append the Fletcher-8 pair over offset 2 onward; a nonzero flip corrupts it.
  task automatic seal_frame(input logic [7:0] flip_a, input logic [7:0] flip_b);
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    ck_a = '0;
    ck_b = '0;
    for (int i = 2; i < frame_q.size(); i++) begin
      ck_a = ck_a + frame_q[i];
      ck_b = ck_b + ck_a;
    end
    frame_q.push_back(ck_a ^ flip_a);
    frame_q.push_back(ck_b ^ flip_b);
  endtask

  // Mostly well-formed frames of 4..16 bytes with random content; the rest are
  // corrupted check pairs, short frames and plain noise.
  task automatic random_frame();
    int         pick;
    logic [7:0] flip_a;
    logic [7:0] flip_b;
    pick = $urandom_range(99);
    frame_q.delete();
    if (pick < 78) begin
      // sync bytes are not checked, so sometimes send garbage there
      frame_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : ubxfc_pkg::SYNC_1);
      frame_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : ubxfc_pkg::SYNC_2);
      repeat ($urandom_range(12)) frame_q.push_back(8'($urandom));
      flip_a = '0;
      flip_b = '0;
      if (pick >= 60) begin
        flip_a = 8'($urandom);
        flip_b = 8'($urandom);
        if (flip_a == 8'h00 && flip_b == 8'h00) flip_b = 8'h80;
      end
      seal_frame(flip_a, flip_b);
    end else if (pick < 90) begin
      repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(12, 4)) frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic run_random(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      random_frame();
      send_frame();
      sent += frame_q.size();
    end
  endtask

  // Let the block go idle: sender off, all results in, then a few spare cycles.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // Called at a rising edge with the block idle.
  task automatic write_capacity(input logic [3:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, capacity at its reset value of 8.
    // Shortest good frame: nothing summed, check pair is zero, class/id zero.
    frame_q = '{ubxfc_pkg::SYNC_1, ubxfc_pkg::SYNC_2, 8'h00, 8'h00};
    send_frame();
    // One-byte frame, all ones: too short.
    frame_q = '{8'hFF};
    send_frame();
    // Three bytes: one short of the minimum.
    frame_q = '{8'h00, 8'hFF, 8'h5A};
    send_frame();
    // All-ones class and id.
    frame_q = '{ubxfc_pkg::SYNC_1, ubxfc_pkg::SYNC_2, 8'hFF, 8'hFF};
    seal_frame(8'h00, 8'h00);
    send_frame();
    // Check pair off by one bit in ck_b.
    frame_q = '{ubxfc_pkg::SYNC_1, ubxfc_pkg::SYNC_2, 8'h06, 8'h01};
    seal_frame(8'h00, 8'h01);
    send_frame();
    // Zero capacity: a good frame gives a lone status result. Sync bytes zero.
    settle();
    write_capacity(4'd0);
    frame_q = '{8'h00, 8'h00, 8'h0A, 8'h0B};
    seal_frame(8'h00, 8'h00);
    send_frame();

    // Random part; sender rarely idles, receiver stalls often.
    settle();
    write_capacity(4'd15);
    run_random(34);
    settle();
    write_capacity(4'($urandom_range(7, 1)));
    run_random(34);

    // Sender idles often, receiver rarely stalls.
    in_gap_pct    <= 55;
    out_stall_pct <= 13;
    settle();
    write_capacity(4'd0);
    run_random(34);
    settle();
    write_capacity(4'($urandom_range(15, 9)));
    run_random(34);

    // Full throughput on both sides.
    in_gap_pct    <= 0;
    out_stall_pct <= 0;
    settle();
    write_capacity(4'($urandom_range(15)));
    run_random(34);
    settle();
    write_capacity(4'd8);
    run_random(34);

    // Drain, then give a late spurious result time to show up.
    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ubxfc_pkg.sv
src/ubxfc_frame_track.sv
src/ubxfc_ack_emit.sv
src/ubx_frame_check_and_ack.sv
bench/ubxfc_checker.sv
bench/tb.sv
